// ----- rtl/bmh_pkg.sv -----
// Shared types and constants for the binary max heap engine.
// No dependencies; imported by every module in rtl/ except bmh_ram.
package bmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // child index width: 2*pos+2 can reach 2*CAPACITY, which needs two bits beyond the address
    localparam int CHILD_W  = ADDR_W + 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 3'd0,
        OP_BUILD   = 3'd1,
        OP_EXTRACT = 3'd2,
        OP_INCKEY  = 3'd3,
        OP_SORT    = 3'd4,
        OP_READ    = 3'd5
    } op_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_REJECTED = 3'd3,
        ST_FULL     = 3'd4,
        ST_RANGE    = 3'd5
    } status_code_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] new_value;
        logic [INDEX_W-1:0]        index;
    } req_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [STATUS_W-1:0]       status;
        logic [CNT_W-1:0]          heap_count;
    } rsp_item_t;

    // datapath micro-operations issued by the controller, one per cycle
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_LOAD_WR,
        DP_RD_IDX,
        DP_RES_RD,
        DP_BUILD_INIT,
        DP_HEAP_INIT,
        DP_HEAP_STEP,
        DP_V_RD,
        DP_SD_RL,
        DP_SD_RR,
        DP_SD_CMP,
        DP_RD_ROOT,
        DP_RD_LAST,
        DP_SWAP,
        DP_SR_INIT,
        DP_SR_RD,
        DP_SR_HIT,
        DP_SU_RP,
        DP_SU_CMP,
        DP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t       op;
        logic         extract;
        status_code_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic sc_full;
        logic hs_zero;
        logic key_gt_new;
        logic idx_ok;
        logic iter_zero;
        logic iter_end;
        logic match;
        logic sd_done;
        logic pos_zero;
        logic su_stop;
    } dp_status_t;

endpackage

// ----- rtl/bmh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bmh_datapath.sv -----
// Heap datapath: store RAM, size counters, sift registers, output register.
// Depends on bmh_pkg and bmh_ram.
module bmh_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  bmh_pkg::req_item_t  req,
    input  bmh_pkg::dp_cmd_t    cmd,
    output bmh_pkg::dp_status_t flags,
    output bmh_pkg::rsp_item_t  rsp
);
    import bmh_pkg::*;

    req_item_t                 item_reg, item_next;
    rsp_item_t                 rsp_reg, rsp_next;
    logic [CNT_W-1:0]          sc_reg, sc_next;
    logic [CNT_W-1:0]          hs_reg, hs_next;
    logic [CNT_W-1:0]          iter_reg, iter_next;
    logic [ADDR_W-1:0]         pos_reg, pos_next;
    logic signed [VALUE_W-1:0] v_reg, v_next;
    logic signed [VALUE_W-1:0] lval_reg, lval_next;
    logic signed [VALUE_W-1:0] root_reg, root_next;
    logic signed [VALUE_W-1:0] res_reg, res_next;

    logic                      we;
    logic [ADDR_W-1:0]         waddr, raddr;
    logic signed [VALUE_W-1:0] wdata, rdata;

    logic [CHILD_W-1:0]        left, right, hs_ext;
    logic                      left_ok, right_ok, lgt, rgt;
    logic signed [VALUE_W-1:0] cmpv, best_val;
    logic [ADDR_W-1:0]         best_idx, parent, last, iter_m1;

    bmh_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign left     = {1'b0, pos_reg, 1'b1};
    assign right    = left + CHILD_W'(1);
    assign hs_ext   = CHILD_W'(hs_reg);
    assign left_ok  = left < hs_ext;
    assign right_ok = right < hs_ext;
    assign lgt      = left_ok && (lval_reg > v_reg);
    assign cmpv     = lgt ? lval_reg : v_reg;
    assign rgt      = right_ok && (rdata > cmpv);
    assign best_val = rgt ? rdata : lval_reg;
    assign best_idx = rgt ? right[ADDR_W-1:0] : left[ADDR_W-1:0];
    assign parent   = (pos_reg - ADDR_W'(1)) >> 1;
    assign last     = ADDR_W'(hs_reg - CNT_W'(1));
    assign iter_m1  = ADDR_W'(iter_reg - CNT_W'(1));

    always_comb
    begin
        flags.sc_full    = sc_reg == CNT_W'(CAPACITY);
        flags.hs_zero    = hs_reg == '0;
        flags.key_gt_new = item_reg.value > item_reg.new_value;
        flags.idx_ok     = (CNT_W + INDEX_W)'(item_reg.index) < (CNT_W + INDEX_W)'(sc_reg);
        flags.iter_zero  = iter_reg == '0;
        flags.iter_end   = iter_reg >= hs_reg;
        flags.match      = rdata == item_reg.value;
        flags.sd_done    = !(lgt || rgt);
        flags.pos_zero   = pos_reg == '0;
        flags.su_stop    = !(v_reg > rdata);
    end

    always_comb
    begin
        item_next = item_reg;
        rsp_next  = rsp_reg;
        sc_next   = sc_reg;
        hs_next   = hs_reg;
        iter_next = iter_reg;
        pos_next  = pos_reg;
        v_next    = v_reg;
        lval_next = lval_reg;
        root_next = root_reg;
        res_next  = res_reg;
        we        = 1'b0;
        waddr     = pos_reg;
        wdata     = v_reg;
        raddr     = '0;
        case (cmd.op)
            DP_LATCH:
            begin
                item_next = req;
                res_next  = '0;
            end
            DP_LOAD_WR:
            begin
                we      = 1'b1;
                waddr   = ADDR_W'(sc_reg);
                wdata   = item_reg.value;
                sc_next = sc_reg + CNT_W'(1);
            end
            DP_RD_IDX:     raddr = ADDR_W'(item_reg.index);
            DP_RES_RD:     res_next = rdata;
            DP_BUILD_INIT:
            begin
                hs_next   = sc_reg;
                iter_next = (sc_reg >> 1) + CNT_W'(1);
            end
            DP_HEAP_INIT:  iter_next = (hs_reg >> 1) + CNT_W'(1);
            DP_HEAP_STEP:
            begin
                iter_next = iter_reg - CNT_W'(1);
                pos_next  = iter_m1;
                raddr     = iter_m1;
            end
            DP_V_RD:       v_next = rdata;
            DP_SD_RL:      raddr = left[ADDR_W-1:0];
            DP_SD_RR:
            begin
                raddr     = right[ADDR_W-1:0];
                lval_next = rdata;
            end
            DP_SD_CMP:
            begin
                we = 1'b1;
                if (!flags.sd_done)
                begin
                    wdata    = best_val;
                    pos_next = best_idx;
                end
            end
            DP_RD_ROOT:    raddr = '0;
            DP_RD_LAST:
            begin
                root_next = rdata;
                raddr     = last;
                if (cmd.extract)
                begin
                    res_next = rdata;
                end
            end
            DP_SWAP:
            begin
                v_next   = rdata;
                we       = 1'b1;
                waddr    = last;
                wdata    = root_reg;
                hs_next  = hs_reg - CNT_W'(1);
                pos_next = '0;
                if (cmd.extract && sc_reg != '0)
                begin
                    sc_next = sc_reg - CNT_W'(1);
                end
            end
            DP_SR_INIT:    iter_next = '0;
            DP_SR_RD:
            begin
                raddr     = ADDR_W'(iter_reg);
                iter_next = iter_reg + CNT_W'(1);
            end
            DP_SR_HIT:
            begin
                pos_next = iter_m1;
                v_next   = item_reg.new_value;
            end
            DP_SU_RP:
            begin
                if (flags.pos_zero)
                begin
                    we = 1'b1;
                end
                else
                begin
                    raddr = parent;
                end
            end
            DP_SU_CMP:
            begin
                we = 1'b1;
                if (!flags.su_stop)
                begin
                    wdata    = rdata;
                    pos_next = parent;
                end
            end
            DP_PUSH:
            begin
                rsp_next.result_value = res_reg;
                rsp_next.status       = cmd.status;
                rsp_next.heap_count   = hs_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg <= '0;
            hs_reg <= '0;
        end
        else
        begin
            sc_reg <= sc_next;
            hs_reg <= hs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
        iter_reg <= iter_next;
        pos_reg  <= pos_next;
        v_reg    <= v_next;
        lval_reg <= lval_next;
        root_reg <= root_next;
        res_reg  <= res_next;
    end

    assign rsp = rsp_reg;

    a_hs_le_sc: assert property (@(posedge clk) disable iff (!rst_n) hs_reg <= sc_reg)
        else $error("heap size exceeds stored count");
    a_sc_cap: assert property (@(posedge clk) disable iff (!rst_n)
        sc_reg <= CNT_W'(CAPACITY))
        else $error("stored count beyond capacity");
    a_swap_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_SWAP) |-> !flags.hs_zero)
        else $error("swap issued on empty heap");

endmodule

// ----- rtl/bmh_ctrl.sv -----
// Heap controller: one-hot sequencer that issues datapath micro-operations.
// Depends on bmh_pkg.
module bmh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [bmh_pkg::OP_W-1:0] req_op,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  bmh_pkg::dp_status_t flags,
    output bmh_pkg::dp_cmd_t    cmd
);
    import bmh_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE      = 17'h00001,
        S_DEC       = 17'h00002,
        S_RD_WAIT   = 17'h00004,
        S_HEAP_NEXT = 17'h00008,
        S_V_LOAD    = 17'h00010,
        S_SD_RL     = 17'h00020,
        S_SD_RR     = 17'h00040,
        S_SD_CMP    = 17'h00080,
        S_SORT_NEXT = 17'h00100,
        S_EX_RL     = 17'h00200,
        S_EX_SW     = 17'h00400,
        S_SR_RD     = 17'h00800,
        S_SR_CHK    = 17'h01000,
        S_SU_RP     = 17'h02000,
        S_SU_CMP    = 17'h04000,
        S_DONE      = 17'h08000,
        S_EX_R0     = 17'h10000
    } state_t;

    state_t           state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    status_code_t     status_reg, status_next;
    logic             phase_reg, phase_next;
    logic             out_valid_reg, out_valid_next;
    logic             is_extract, accept;

    assign is_extract = op_reg == OP_EXTRACT;
    assign req_ready  = state_reg == S_IDLE;
    assign accept     = req_valid && req_ready;
    assign rsp_valid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd.op         = DP_NOP;
        cmd.extract    = is_extract;
        cmd.status     = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op      = DP_LATCH;
                    op_next     = req_op;
                    status_next = ST_OK;
                    phase_next  = 1'b0;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_LOAD:
                    begin
                        if (flags.sc_full) status_next = ST_FULL;
                        else cmd.op = DP_LOAD_WR;
                    end
                    OP_BUILD:
                    begin
                        cmd.op     = DP_BUILD_INIT;
                        state_next = S_HEAP_NEXT;
                    end
                    OP_EXTRACT:
                    begin
                        if (flags.hs_zero) status_next = ST_EMPTY;
                        else
                        begin
                            cmd.op     = DP_RD_ROOT;
                            state_next = S_EX_RL;
                        end
                    end
                    OP_INCKEY:
                    begin
                        if (flags.key_gt_new) status_next = ST_REJECTED;
                        else
                        begin
                            cmd.op     = DP_SR_INIT;
                            state_next = S_SR_RD;
                        end
                    end
                    OP_SORT:
                    begin
                        cmd.op     = DP_HEAP_INIT;
                        state_next = S_HEAP_NEXT;
                    end
                    OP_READ:
                    begin
                        if (flags.idx_ok)
                        begin
                            cmd.op     = DP_RD_IDX;
                            state_next = S_RD_WAIT;
                        end
                        else status_next = ST_RANGE;
                    end
                    default: ;
                endcase
            end
            S_RD_WAIT:
            begin
                cmd.op     = DP_RES_RD;
                state_next = S_DONE;
            end
            S_HEAP_NEXT:
            begin
                if (flags.iter_zero)
                begin
                    if (op_reg == OP_SORT)
                    begin
                        phase_next = 1'b1;
                        state_next = S_SORT_NEXT;
                    end
                    else state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_HEAP_STEP;
                    state_next = S_V_LOAD;
                end
            end
            S_V_LOAD:
            begin
                cmd.op     = DP_V_RD;
                state_next = S_SD_RL;
            end
            S_SD_RL:
            begin
                cmd.op     = DP_SD_RL;
                state_next = S_SD_RR;
            end
            S_SD_RR:
            begin
                cmd.op     = DP_SD_RR;
                state_next = S_SD_CMP;
            end
            S_SD_CMP:
            begin
                cmd.op = DP_SD_CMP;
                if (!flags.sd_done) state_next = S_SD_RL;
                else if (is_extract) state_next = S_DONE;
                else if (phase_reg) state_next = S_SORT_NEXT;
                else state_next = S_HEAP_NEXT;
            end
            S_SORT_NEXT:
            begin
                if (flags.hs_zero) state_next = S_DONE;
                else
                begin
                    cmd.op     = DP_RD_ROOT;
                    state_next = S_EX_RL;
                end
            end
            S_EX_R0:   state_next = S_EX_RL;
            S_EX_RL:
            begin
                cmd.op     = DP_RD_LAST;
                state_next = S_EX_SW;
            end
            S_EX_SW:
            begin
                cmd.op     = DP_SWAP;
                state_next = S_SD_RL;
            end
            S_SR_RD:
            begin
                if (flags.iter_end)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_SR_RD;
                    state_next = S_SR_CHK;
                end
            end
            S_SR_CHK:
            begin
                if (flags.match)
                begin
                    cmd.op     = DP_SR_HIT;
                    state_next = S_SU_RP;
                end
                else state_next = S_SR_RD;
            end
            S_SU_RP:
            begin
                cmd.op     = DP_SU_RP;
                state_next = flags.pos_zero ? S_DONE : S_SU_CMP;
            end
            S_SU_CMP:
            begin
                cmd.op     = DP_SU_CMP;
                state_next = flags.su_stop ? S_DONE : S_SU_RP;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.op         = DP_PUSH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            status_reg    <= ST_OK;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            status_reg    <= status_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DEC)
        else $error("accepted transfer not decoded");
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !rsp_ready) |=> state_reg == S_DONE)
        else $error("result dropped while output stalled");
    a_phase_sort: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> op_reg == OP_SORT)
        else $error("sort phase set outside sort");

endmodule

// ----- rtl/binary_max_heap_engine.sv -----
// Top level of the binary max heap engine: controller plus datapath.
// Depends on bmh_pkg, bmh_ctrl, bmh_datapath (which uses bmh_ram).
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  bmh_pkg::req_item_t
//  rsp      out        rsp_valid / rsp_ready  bmh_pkg::rsp_item_t
//
// One item at a time. Extract sifts down one heap level per pass (one RAM
// read port, one read per child); increase-key searches the entries in order,
// then sifts up level by level; build runs one sift-down per node from half
// the heap size down to the root, and sort adds one per extracted entry.
// Reset clears counters and control only; the store needs no clearing.
// A finished result waits in the output register while the next request is taken.
module binary_max_heap_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bmh_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output bmh_pkg::rsp_item_t rsp
);
    import bmh_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t flags;

    bmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_op    (req.op),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    bmh_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .flags (flags),
        .rsp   (rsp)
    );

endmodule

// ----- verif/bmh_checker.sv -----
// Response checker for binary_max_heap_engine: watches both channels,
// keeps its own shadow heap and compares every response transfer.
// Depends on bmh_pkg.
`timescale 1ns / 100ps

module bmh_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  bmh_pkg::req_item_t req,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  bmh_pkg::rsp_item_t rsp,
    output int                 errors,
    output int                 pending,
    output int                 stored_n,
    output int                 heap_n
);
    import bmh_pkg::*;

    logic signed [VALUE_W-1:0] shadow [CAPACITY];
    int unsigned n_stored = 0;
    int unsigned n_heap = 0;
    int          err_cnt = 0;
    int          pend_cnt = 0;
    rsp_item_t   answers_q [$];
    rsp_item_t   want;

    assign errors   = err_cnt;
    assign pending  = pend_cnt;
    assign stored_n = int'(n_stored);
    assign heap_n   = int'(n_heap);

    task automatic report(input string what, input longint got, input longint exp);
        err_cnt++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp);
    endtask

    function automatic void swap_at(int unsigned a, int unsigned b);
        logic signed [VALUE_W-1:0] t;
        t = shadow[a];
        shadow[a] = shadow[b];
        shadow[b] = t;
    endfunction

    function automatic void sift_down(int unsigned pos);
        int unsigned l, r, best;
        forever
        begin
            l = pos * 2 + 1;
            r = pos * 2 + 2;
            best = pos;
            if (l < n_heap && shadow[l] > shadow[best])
                best = l;
            if (r < n_heap && shadow[r] > shadow[best])
                best = r;
            if (best == pos)
                return;
            swap_at(best, pos);
            pos = best;
        end
    endfunction

    function automatic void sift_up(int unsigned pos);
        int unsigned parent;
        while (pos > 0)
        begin
            parent = (pos - 1) / 2;
            if (!(shadow[pos] > shadow[parent]))
                return;
            swap_at(parent, pos);
            pos = parent;
        end
    endfunction

    function automatic void heapify();
        int unsigned i;
        i = n_heap / 2 + 1;
        while (i > 0)
        begin
            i--;
            sift_down(i);
        end
    endfunction

    function automatic rsp_item_t heap_answer(input req_item_t r);
        rsp_item_t   o;
        int unsigned i;
        o = '0;
        o.status = ST_OK;
        case (r.op)
            OP_LOAD:
            begin
                if (n_stored >= CAPACITY)
                    o.status = ST_FULL;
                else
                begin
                    shadow[n_stored] = r.value;
                    n_stored++;
                end
            end
            OP_BUILD:
            begin
                n_heap = n_stored;
                heapify();
            end
            OP_EXTRACT:
            begin
                if (n_heap == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    o.result_value = shadow[0];
                    swap_at(0, n_heap - 1);
                    n_heap--;
                    if (n_stored > 0)
                        n_stored--;
                    sift_down(0);
                end
            end
            OP_INCKEY:
            begin
                if (r.value > r.new_value)
                    o.status = ST_REJECTED;
                else
                begin
                    i = 0;
                    while (i < n_heap && shadow[i] != r.value)
                        i++;
                    if (i >= n_heap)
                        o.status = ST_NOTFOUND;
                    else
                    begin
                        shadow[i] = r.new_value;
                        sift_up(i);
                    end
                end
            end
            OP_SORT:
            begin
                heapify();
                while (n_heap > 0)
                begin
                    swap_at(0, n_heap - 1);
                    n_heap--;
                    sift_down(0);
                end
            end
            OP_READ:
            begin
                if (r.index < n_stored)
                    o.result_value = shadow[r.index];
                else
                    o.status = ST_RANGE;
            end
            default: ;
        endcase
        o.heap_count = n_heap[CNT_W-1:0];
        return o;
    endfunction

    // response side first: a response can never belong to a request taken on the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (answers_q.size() == 0)
                    report("unexpected response, status", rsp.status, -1);
                else
                begin
                    want = answers_q.pop_front();
                    if (rsp.result_value !== want.result_value)
                        report("result_value", rsp.result_value, want.result_value);
                    if (rsp.status !== want.status)
                        report("status", rsp.status, want.status);
                    if (rsp.heap_count !== want.heap_count)
                        report("heap_count", rsp.heap_count, want.heap_count);
                end
            end
            if (req_valid && req_ready)
                answers_q = {answers_q, heap_answer(req)};
            pend_cnt = answers_q.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for binary_max_heap_engine: clock, reset, request stimulus,
// response backpressure and verdict. Depends on bmh_pkg and bmh_checker.
`timescale 1ns / 100ps

module tb_top;
    import bmh_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    int errors, pending, stored_n, heap_n;
    int send_idle = 0;
    int recv_idle = 0;
    logic stall_req = 1'b0;

    binary_max_heap_engine uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    bmh_checker chk (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .errors(errors), .pending(pending), .stored_n(stored_n), .heap_n(heap_n)
    );

    always #5 clk = ~clk;

    // receiver backpressure, with one long hold-off on request
    int  hold_left = 0;
    bit  hold_done = 0;
    always @(posedge clk)
    begin
        if (stall_req && !hold_done)
        begin
            hold_done = 1;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send(input op_code_t op, input int v, input int nv, input int idx);
        req_item_t it;
        it.op = op;
        it.value = v;
        it.new_value = nv;
        it.index = idx[INDEX_W-1:0];
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $signed($urandom_range(15)) - 8;
        else if (r < 75)
            return 32'sh7fffffff;
        else if (r < 80)
            return 32'sh80000000;
        return $urandom;
    endfunction

    task automatic random_item();
        int r;
        logic signed [31:0] k;
        op_code_t op;
        r = $urandom_range(99);
        k = pick_key();
        if (stored_n > 40 && heap_n < stored_n / 2)
            op = OP_BUILD;
        else if (stored_n > 40 && r < 60)
            op = OP_EXTRACT;
        else if (r < 35)
            op = OP_LOAD;
        else if (r < 45)
            op = OP_BUILD;
        else if (r < 68)
            op = OP_EXTRACT;
        else if (r < 80)
            op = OP_INCKEY;
        else if (r < 84)
            op = OP_SORT;
        else if (r < 96)
            op = OP_READ;
        else
            op = op_code_t'(3'd6 + $urandom_range(1));
        if (op == OP_INCKEY && $urandom_range(3) != 0)
            send(op, k, k + $signed($urandom_range(20)), $urandom);
        else
            send(op, k, pick_key(), $urandom);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, all ops, unused codes
        send(OP_EXTRACT, 0, 0, 0);
        send(OP_READ, 0, 0, 0);
        send(OP_INCKEY, 1, 2, 0);
        send(OP_INCKEY, 5, 3, 0);
        send(op_code_t'(3'd6), -1, -1, 1023);
        send(op_code_t'(3'd7), 0, 0, 0);
        send(OP_LOAD, 32'sh7fffffff, 0, 0);
        send(OP_LOAD, 32'sh80000000, 0, 0);
        send(OP_LOAD, 0, 0, 0);
        send(OP_LOAD, -1, 0, 0);
        send(OP_LOAD, 7, 0, 0);
        send(OP_READ, 0, 0, 1);
        send(OP_READ, 0, 0, 1023);
        send(OP_INCKEY, -1, -1, 0);
        send(OP_BUILD, 0, 0, 0);
        send(OP_INCKEY, -1, 100, 0);
        send(OP_INCKEY, 0, 0, 0);
        send(OP_EXTRACT, 0, 0, 0);
        send(OP_LOAD, 3, 0, 0);
        send(OP_EXTRACT, 0, 0, 0);
        send(OP_SORT, 0, 0, 0);
        send(OP_READ, 0, 0, 0);
        send(OP_READ, 0, 0, 3);
        send(OP_EXTRACT, 0, 0, 0);
        send(OP_BUILD, 0, 0, 0);
        drain();

        send_idle = 24;
        recv_idle = 50;
        repeat (200) random_item();
        send_idle = 50;
        recv_idle = 24;
        stall_req <= 1'b1;
        repeat (200) random_item();
        send_idle = 0;
        recv_idle = 0;
        repeat (200) random_item();
        drain();

        // closing pass over whatever the store holds
        send(OP_READ, 0, 0, 1023);
        send(OP_BUILD, 0, 0, 0);
        send(OP_INCKEY, 32'sh7ffffffe, 32'sh7fffffff, 0);
        repeat (3) send(OP_EXTRACT, 0, 0, 0);
        send(OP_SORT, 0, 0, 0);
        send(OP_READ, 0, 0, 0);
        send(OP_READ, 0, 0, 1022);
        drain();

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bmh_pkg.sv
rtl/bmh_ram.sv
rtl/bmh_datapath.sv
rtl/bmh_ctrl.sv
rtl/binary_max_heap_engine.sv
verif/bmh_checker.sv
verif/tb_top.sv
